// File: rtl/dnle_pkg.sv
// Shared constants and types of the DNS name label encoder.
package dnle_pkg;

  localparam int DATA_W      = 8;
  localparam int STORE_DEPTH = 62;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LEN_W       = $clog2(STORE_DEPTH + 1);

  localparam logic [DATA_W-1:0] DOT_CHAR = 8'h2E;
  localparam logic [DATA_W-1:0] NUL_CHAR = 8'h00;

  // what the output register is loaded with
  typedef enum logic [1:0] {
    SEL_LEN,
    SEL_CHAR,
    SEL_TERM
  } out_sel_t;

  typedef struct packed {
    logic     store_char;  // buffer the accepted character
    logic     load_out;    // load a word into the output register
    out_sel_t out_sel;
    logic     clr_len;     // label fully replayed
  } dp_cmd_t;

  typedef struct packed {
    logic is_dot;     // input word is a separator
    logic len_zero;   // nothing buffered
    logic last_char;  // next character word is the label's last
    logic out_free;   // output register can take a word this cycle
  } dp_sts_t;

endpackage

// File: rtl/dnle_ctrl.sv
// Sequencer of the DNS name label encoder: accept, length, replay, terminator.
module dnle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tlast,
  input  dnle_pkg::dp_sts_t sts,
  output dnle_pkg::dp_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEN  = 2'd1;
  localparam logic [1:0] ST_DATA = 2'd2;
  localparam logic [1:0] ST_TERM = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       end_r, end_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    end_nxt        = end_r;
    cmd.store_char = 1'b0;
    cmd.load_out   = 1'b0;
    cmd.out_sel    = dnle_pkg::SEL_LEN;
    cmd.clr_len    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tlast) begin
            end_nxt   = 1'b1;
            state_nxt = ST_LEN;
          end else if (sts.is_dot) begin
            end_nxt   = 1'b0;
            state_nxt = ST_LEN;
          end else begin
            cmd.store_char = 1'b1;
          end
        end
      end
      ST_LEN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = dnle_pkg::SEL_LEN;
          if (!sts.len_zero) begin
            state_nxt = ST_DATA;
          end else if (end_r) begin
            state_nxt = ST_TERM;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = dnle_pkg::SEL_CHAR;
          if (sts.last_char) begin
            cmd.clr_len = 1'b1;
            state_nxt   = end_r ? ST_TERM : ST_IDLE;
          end
        end
      end
      ST_TERM: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_sel  = dnle_pkg::SEL_TERM;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule

// File: rtl/dnle_dp.sv
// Datapath of the DNS name label encoder: label store, counters, output register.
module dnle_dp #(
  parameter int LABEL_MAX = 62
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [dnle_pkg::DATA_W-1:0]   in_tdata,
  input  dnle_pkg::dp_cmd_t             cmd,
  output dnle_pkg::dp_sts_t             sts,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [dnle_pkg::DATA_W-1:0]   out_tdata,
  output logic                          out_tlast,
  output logic                          out_tuser
);

  localparam int CAP = (LABEL_MAX < dnle_pkg::STORE_DEPTH) ? LABEL_MAX
                                                           : dnle_pkg::STORE_DEPTH;
  localparam int AW  = dnle_pkg::ADDR_W;
  localparam int LW  = dnle_pkg::LEN_W;
  localparam int DW  = dnle_pkg::DATA_W;

  logic [DW-1:0] store_mem [dnle_pkg::STORE_DEPTH];
  logic [DW-1:0] rd_data_r;

  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] ptr_r, ptr_nxt;   // next store address to fetch
  logic          ovf_r, ovf_nxt;
  logic          at_cap;
  logic          fetch_en;
  logic [AW-1:0] fetch_addr;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_user_r, out_user_nxt;

  assign at_cap = (len_r >= LW'(CAP));

  assign sts.is_dot    = (in_tdata == dnle_pkg::DOT_CHAR);
  assign sts.len_zero  = (len_r == '0);
  assign sts.last_char = (ptr_r == len_r);
  assign sts.out_free  = !out_valid_r || out_tready;

  always_comb begin
    len_nxt       = len_r;
    ptr_nxt       = ptr_r;
    ovf_nxt       = ovf_r;
    fetch_en      = 1'b0;
    fetch_addr    = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_user_nxt  = out_user_r;

    if (cmd.store_char) begin
      if (at_cap) begin
        ovf_nxt = 1'b1;      // character dropped
      end else begin
        len_nxt = len_r + 1'b1;
      end
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
      out_user_nxt  = ovf_r;
      out_last_nxt  = 1'b0;
      case (cmd.out_sel)
        dnle_pkg::SEL_LEN: begin
          out_data_nxt = DW'(len_r);
          fetch_en     = 1'b1;
          fetch_addr   = '0;
          ptr_nxt      = LW'(1);
        end
        dnle_pkg::SEL_CHAR: begin
          out_data_nxt = rd_data_r;
          fetch_en     = (ptr_r != len_r);
          fetch_addr   = ptr_r[AW-1:0];
          ptr_nxt      = ptr_r + 1'b1;
        end
        dnle_pkg::SEL_TERM: begin
          out_data_nxt = dnle_pkg::NUL_CHAR;
          out_last_nxt = 1'b1;
          ovf_nxt      = 1'b0;
        end
        default: begin
          out_valid_nxt = 1'b0;
        end
      endcase
    end

    if (cmd.clr_len) begin
      len_nxt = '0;
    end
  end

  // label store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store_char && !at_cap) begin
      store_mem[len_r[AW-1:0]] <= in_tdata;
    end
    if (fetch_en) begin
      rd_data_r <= store_mem[fetch_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

endmodule

// File: rtl/dns_name_label_encoder.sv
// A character word is buffered and gives no output word; a dot or end word with n
// buffered characters goes through the length state, which registers its length word,
// then one character word per cycle while the output is not stalled; end adds the
// terminator. Input is held off from a dot or end word until its label and, after end,
// the terminator are loaded into one output register fed by the store's one read port.
// Reset: rst_n synchronous, active low; clears sequencer, length, overflow and out valid.
module dns_name_label_encoder #(
  parameter int LABEL_MAX = 62   // longest label kept, 1 to 62
) (
  input  logic       clk,
  input  logic       rst_n,
  // input stream: one host name character per word
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] name_byte
  input  logic       in_tlast,    // end_of_name; in_tdata ignored then
  // output stream: wire-format name bytes
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast,   // is_final, on the zero terminator
  output logic       out_tuser    // label_overflow
);

  dnle_pkg::dp_cmd_t cmd;
  dnle_pkg::dp_sts_t sts;

  // sequencer: decides when to buffer, when to emit length, chars, terminator
  dnle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tlast  (in_tlast),
    .sts       (sts),
    .cmd       (cmd)
  );

  // label store, length and overflow tracking, output register
  dnle_dp #(
    .LABEL_MAX (LABEL_MAX)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// File: rtl/dnle_chk.sv
// Port-level checker of the DNS name label encoder and its bind.
module dnle_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast,
  input logic       out_tuser
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("output word changed while stalled");

  // terminator is a zero byte
  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata == dnle_pkg::NUL_CHAR)
    else $error("terminator word not zero");

  // a dot or end word starts a flush, so input is held off next cycle
  a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tlast || in_tdata == dnle_pkg::DOT_CHAR) |=> !in_tready)
    else $error("input taken during label flush");

endmodule

bind dns_name_label_encoder dnle_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
